// ----- rtl/snc_pkg.sv -----
// Shared types, widths and constants for the segment near-clip projection block.
// Depends on nothing; every other file imports it.
package snc_pkg;

    localparam int WORLD_BITS    = 32;
    localparam int SCREEN_BITS   = 20;
    localparam int CENTRE_BITS   = 20;
    localparam int AXIS_BITS     = 16;
    localparam int AXIS_FRAC     = 14;
    localparam int AXIS_REG_BITS = 3 * AXIS_BITS;
    localparam int FOCAL_BITS    = 24;
    localparam int FOCAL_RESET   = 256;
    localparam int HIDE_DEPTH    = 7;
    localparam int CLIP_DEPTH    = 8;
    localparam int T_BITS        = 16;
    localparam int DEN_SHIFT     = 4;

    localparam int REL_BITS   = WORLD_BITS + 1;
    localparam int PROD_BITS  = REL_BITS + AXIS_BITS;
    localparam int SUM_BITS   = PROD_BITS + 2;
    localparam int DOT_BITS   = SUM_BITS - AXIS_FRAC;
    localparam int DEP_BITS   = DOT_BITS - 1;
    localparam int SPAN_BITS  = DOT_BITS + 1;
    localparam int REM_BITS   = SPAN_BITS + 1;
    localparam int DELTA_BITS = REL_BITS + 1;
    localparam int TPROD_BITS = DELTA_BITS + T_BITS + 2;
    localparam int MAG_BITS   = DOT_BITS;
    localparam int MULT_BITS  = MAG_BITS + FOCAL_BITS;
    localparam int NUM_BITS   = MULT_BITS - DEN_SHIFT;
    localparam int Q_BITS     = (SCREEN_BITS > CENTRE_BITS ? SCREEN_BITS : CENTRE_BITS) + 1;
    localparam int DIV_BITS   = (NUM_BITS > DEP_BITS + Q_BITS) ? NUM_BITS : DEP_BITS + Q_BITS;
    localparam int SX_BITS    = Q_BITS + 3;

    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 48;

    typedef logic signed [WORLD_BITS-1:0]  world_t;
    typedef logic [2:0][WORLD_BITS-1:0]    wvec_t;
    typedef logic signed [REL_BITS-1:0]    rel_t;
    typedef logic [2:0][REL_BITS-1:0]      vec_t;
    typedef logic [2:0][DELTA_BITS-1:0]    dvec_t;
    typedef logic signed [AXIS_BITS-1:0]   axis_t;
    typedef logic [AXIS_REG_BITS-1:0]      axes_t;
    typedef logic signed [PROD_BITS-1:0]   prod_t;
    typedef logic signed [SUM_BITS-1:0]    sum_t;
    typedef logic signed [DOT_BITS-1:0]    dot_t;
    typedef logic signed [SCREEN_BITS-1:0] screen_t;
    typedef logic signed [SX_BITS-1:0]     sx_t;
    typedef logic signed [TPROD_BITS-1:0]  tprod_t;

    typedef struct packed {
        logic keep;
        vec_t e0;
        vec_t e1;
    } clip_out_t;

    typedef struct packed {
        logic    draw;
        screen_t s0x;
        screen_t s0y;
        screen_t s1x;
        screen_t s1y;
    } line_t;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_EYE_X         = 3'd0,
        REG_EYE_Y         = 3'd1,
        REG_EYE_Z         = 3'd2,
        REG_RIGHT_AXIS    = 3'd3,
        REG_UP_AXIS       = 3'd4,
        REG_FORWARD_AXIS  = 3'd5,
        REG_FOCAL_PIXELS  = 3'd6,
        REG_SCREEN_CENTRE = 3'd7
    } cfg_reg_t;

    localparam dot_t NEAR_DOT = dot_t'(HIDE_DEPTH);
    localparam sx_t  SCR_MAX  = sx_t'((64'sd1 <<< (SCREEN_BITS - 1)) - 64'sd1);
    localparam sx_t  SCR_MIN  = sx_t'(-(64'sd1 <<< (SCREEN_BITS - 1)));

    function automatic axis_t axis_part(axes_t a, logic [1:0] k);
        return a[AXIS_BITS*k +: AXIS_BITS];
    endfunction

endpackage

// ----- rtl/snc_seg_if.sv -----
// Input channel carrying one world-space segment per beat.
// Depends on snc_pkg.
interface snc_seg_if;
    import snc_pkg::*;

    logic   valid;
    logic   ready;
    world_t start_wx;
    world_t start_wy;
    world_t start_wz;
    world_t end_wx;
    world_t end_wy;
    world_t end_wz;

    modport source (output valid, start_wx, start_wy, start_wz, end_wx, end_wy, end_wz,
                    input ready);
    modport sink   (input valid, start_wx, start_wy, start_wz, end_wx, end_wy, end_wz,
                    output ready);
endinterface

// ----- rtl/snc_line_if.sv -----
// Output channel carrying one screen-space line per beat.
// Depends on snc_pkg.
interface snc_line_if;
    import snc_pkg::*;

    logic    valid;
    logic    ready;
    logic    draw_line;
    screen_t start_sx;
    screen_t start_sy;
    screen_t end_sx;
    screen_t end_sy;

    modport source (output valid, draw_line, start_sx, start_sy, end_sx, end_sy,
                    input ready);
    modport sink   (input valid, draw_line, start_sx, start_sy, end_sx, end_sy,
                    output ready);
endinterface

// ----- rtl/segment_near_clip_project.sv -----
// Top level of the segment near-clip projection block: configuration registers
// and the two pipelines. Depends on snc_pkg, snc_seg_if, snc_line_if, snc_clip, snc_project.
//
// Usage:
//   segment : one 3D segment per beat (start/end world x,y,z, signed Q16.16).
//   screen  : one result per segment, in order: draw_line and the two screen
//             endpoints in signed Q16.4, saturated; all zero when dropped.
//   cfg_*   : register write port, one register per cycle when cfg_we is high;
//             write only while no segment is in flight.
// Stages: 49 register stages, 22 of clip front end and 27 of projection. The clip
//   parameter divider takes one quotient bit per stage (16 stages) and the depth
//   divider one bit per stage (21 stages); every stage is registered.
// Throughput: one segment per cycle while screen.ready stays high.
// Stall: each stage holds its beat while the next one is full and blocked, so
//   bubbles fill up before segment.ready drops; nothing is lost or repeated.
// Reset: all stages empty, eye and axes zero (every segment dropped until the
//   forward axis is written), focal 1.0, centre 0. No clearing pass.
module segment_near_clip_project (
    input  logic                              clk,
    input  logic                              rst_n,
    snc_seg_if.sink                           segment,
    snc_line_if.source                        screen,
    input  logic                              cfg_we,
    input  logic [snc_pkg::CFG_ADDR_BITS-1:0] cfg_index,
    input  logic [snc_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    import snc_pkg::*;

    world_t                      eye_x_reg, eye_y_reg, eye_z_reg;
    axes_t                       right_reg, up_reg, forward_reg;
    logic [FOCAL_BITS-1:0]       focal_reg;
    logic [2*CENTRE_BITS-1:0]    centre_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eye_x_reg   <= '0;
            eye_y_reg   <= '0;
            eye_z_reg   <= '0;
            right_reg   <= '0;
            up_reg      <= '0;
            forward_reg <= '0;
            focal_reg   <= FOCAL_BITS'(FOCAL_RESET);
            centre_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_EYE_X:         eye_x_reg   <= cfg_data[WORLD_BITS-1:0];
                REG_EYE_Y:         eye_y_reg   <= cfg_data[WORLD_BITS-1:0];
                REG_EYE_Z:         eye_z_reg   <= cfg_data[WORLD_BITS-1:0];
                REG_RIGHT_AXIS:    right_reg   <= cfg_data[AXIS_REG_BITS-1:0];
                REG_UP_AXIS:       up_reg      <= cfg_data[AXIS_REG_BITS-1:0];
                REG_FORWARD_AXIS:  forward_reg <= cfg_data[AXIS_REG_BITS-1:0];
                REG_FOCAL_PIXELS:  focal_reg   <= cfg_data[FOCAL_BITS-1:0];
                REG_SCREEN_CENTRE: centre_reg  <= cfg_data[2*CENTRE_BITS-1:0];
            endcase
        end
    end

    wvec_t     start_w, end_w, eye_w;
    clip_out_t clip_data;
    logic      clip_valid, clip_ready;
    line_t     line_data;

    assign start_w = {segment.start_wz, segment.start_wy, segment.start_wx};
    assign end_w   = {segment.end_wz, segment.end_wy, segment.end_wx};
    assign eye_w   = {eye_z_reg, eye_y_reg, eye_x_reg};

    // depth, clip parameter, clipped point
    snc_clip u_clip (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (segment.valid),
        .in_ready     (segment.ready),
        .start_w      (start_w),
        .end_w        (end_w),
        .eye          (eye_w),
        .forward_axis (forward_reg),
        .out_valid    (clip_valid),
        .out_ready    (clip_ready),
        .out_data     (clip_data)
    );

    // projection of the final endpoints
    snc_project u_project (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (clip_valid),
        .in_ready     (clip_ready),
        .in_data      (clip_data),
        .right_axis   (right_reg),
        .up_axis      (up_reg),
        .forward_axis (forward_reg),
        .focal        (focal_reg),
        .centre       (centre_reg),
        .out_valid    (screen.valid),
        .out_ready    (screen.ready),
        .out_data     (line_data)
    );

    assign screen.draw_line = line_data.draw;
    assign screen.start_sx  = line_data.s0x;
    assign screen.start_sy  = line_data.s0y;
    assign screen.end_sx    = line_data.s1x;
    assign screen.end_sy    = line_data.s1y;

endmodule

// ----- rtl/snc_dot.sv -----
// Two-stage dot product of a relative vector with one packed Q2.14 axis.
// Depends on snc_pkg.
module snc_dot (
    input  logic          clk,
    input  logic          en_mul,
    input  logic          en_sum,
    input  snc_pkg::vec_t  rel,
    input  snc_pkg::axes_t axis,
    output snc_pkg::dot_t  dot
);
    import snc_pkg::*;

    prod_t prod_reg  [3];
    prod_t prod_next [3];
    sum_t  sum;
    dot_t  dot_reg;
    dot_t  dot_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            prod_next[k] = prod_t'($signed(rel[k])) * prod_t'(axis_part(axis, 2'(k)));
        end
    end

    // exact sum, then floor to Q.16
    always_comb
    begin
        sum      = sum_t'(prod_reg[0]) + sum_t'(prod_reg[1]) + sum_t'(prod_reg[2]);
        dot_next = dot_t'(sum >>> AXIS_FRAC);
    end

    always_ff @(posedge clk)
    begin
        if (en_mul)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod_reg[k] <= prod_next[k];
            end
        end
        if (en_sum)
        begin
            dot_reg <= dot_next;
        end
    end

    assign dot = dot_reg;

endmodule

// ----- rtl/snc_clip.sv -----
// Front pipeline: eye-relative endpoints, forward depth, near-plane clip parameter
// (bit-per-stage divider) and clipped point. Depends on snc_pkg and snc_dot.
module snc_clip (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  snc_pkg::wvec_t     start_w,
    input  snc_pkg::wvec_t     end_w,
    input  snc_pkg::wvec_t     eye,
    input  snc_pkg::axes_t     forward_axis,
    output logic               out_valid,
    input  logic               out_ready,
    output snc_pkg::clip_out_t out_data
);
    import snc_pkg::*;

    localparam int ST_REL  = 0;
    localparam int ST_MUL  = 1;
    localparam int ST_DEP  = 2;
    localparam int ST_PREP = 3;
    localparam int ST_TMUL = ST_PREP + T_BITS + 1;
    localparam int ST_OUT  = ST_TMUL + 1;
    localparam int NST     = ST_OUT + 1;

    logic [NST-1:0] v_reg;
    logic [NST:0]   go;

    // a stage moves when it is empty or the one after it moves
    assign go[NST] = out_ready;
    for (genvar s = 0; s < NST; s++)
    begin : g_go
        assign go[s] = !v_reg[s] || go[s+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int s = 0; s < NST; s++)
            begin
                if (go[s])
                begin
                    v_reg[s] <= (s == 0) ? in_valid : v_reg[s-1];
                end
            end
        end
    end

    assign in_ready  = go[0];
    assign out_valid = v_reg[NST-1];

    // relative positions
    vec_t ra_reg, rb_reg, ra1_reg, rb1_reg, ra2_reg, rb2_reg;
    vec_t ra_next, rb_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            ra_next[k] = rel_t'($signed(start_w[k])) - rel_t'($signed(eye[k]));
            rb_next[k] = rel_t'($signed(end_w[k])) - rel_t'($signed(eye[k]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (go[ST_REL])
        begin
            ra_reg <= ra_next;
            rb_reg <= rb_next;
        end
        if (go[ST_MUL])
        begin
            ra1_reg <= ra_reg;
            rb1_reg <= rb_reg;
        end
        if (go[ST_DEP])
        begin
            ra2_reg <= ra1_reg;
            rb2_reg <= rb1_reg;
        end
    end

    dot_t da, db;

    snc_dot u_depth_a (
        .clk    (clk),
        .en_mul (go[ST_MUL]),
        .en_sum (go[ST_DEP]),
        .rel    (ra_reg),
        .axis   (forward_axis),
        .dot    (da)
    );

    snc_dot u_depth_b (
        .clk    (clk),
        .en_mul (go[ST_MUL]),
        .en_sum (go[ST_DEP]),
        .rel    (rb_reg),
        .axis   (forward_axis),
        .dot    (db)
    );

    // clip setup; with no clip the divider is bypassed (full) so the
    // "clipped" point lands on the far endpoint
    logic                        va, vb, clip, sel, full;
    dot_t                        din, dout;
    logic signed [SPAN_BITS-1:0] num, span_s;
    vec_t                        pin_v, pout_v;
    dvec_t                       delta_v;

    always_comb
    begin
        va     = da > NEAR_DOT;
        vb     = db > NEAR_DOT;
        clip   = va ^ vb;
        sel    = va | ~clip;
        din    = sel ? da : db;
        dout   = sel ? db : da;
        num    = SPAN_BITS'(din) - SPAN_BITS'(CLIP_DEPTH);
        span_s = SPAN_BITS'(din) - SPAN_BITS'(dout);
        full   = ~clip | (num >= span_s);
        pin_v  = sel ? ra2_reg : rb2_reg;
        pout_v = sel ? rb2_reg : ra2_reg;
        for (int k = 0; k < 3; k++)
        begin
            delta_v[k] = DELTA_BITS'($signed(pout_v[k])) - DELTA_BITS'($signed(pin_v[k]));
        end
    end

    logic [REM_BITS-1:0]  rem_reg   [T_BITS+1];
    logic [SPAN_BITS-1:0] span_reg  [T_BITS+1];
    logic [T_BITS-1:0]    q_reg     [T_BITS+1];
    vec_t                 pin_reg   [T_BITS+1];
    dvec_t                delta_reg [T_BITS+1];
    logic                 sel_reg   [T_BITS+1];
    logic                 keep_reg  [T_BITS+1];
    logic                 full_reg  [T_BITS+1];

    always_ff @(posedge clk)
    begin
        if (go[ST_PREP])
        begin
            rem_reg[0]   <= {1'b0, num};
            span_reg[0]  <= span_s;
            q_reg[0]     <= '0;
            pin_reg[0]   <= pin_v;
            delta_reg[0] <= delta_v;
            sel_reg[0]   <= sel;
            keep_reg[0]  <= va | vb;
            full_reg[0]  <= full;
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar j = 1; j <= T_BITS; j++)
    begin : g_div
        logic [REM_BITS-1:0] shifted;
        logic                ge;

        always_comb
        begin
            shifted = rem_reg[j-1] << 1;
            ge      = shifted >= REM_BITS'(span_reg[j-1]);
        end

        always_ff @(posedge clk)
        begin
            if (go[ST_PREP+j])
            begin
                rem_reg[j]   <= ge ? shifted - REM_BITS'(span_reg[j-1]) : shifted;
                q_reg[j]     <= {q_reg[j-1][T_BITS-2:0], ge};
                span_reg[j]  <= span_reg[j-1];
                pin_reg[j]   <= pin_reg[j-1];
                delta_reg[j] <= delta_reg[j-1];
                sel_reg[j]   <= sel_reg[j-1];
                keep_reg[j]  <= keep_reg[j-1];
                full_reg[j]  <= full_reg[j-1];
            end
        end
    end

    // delta * t
    logic [T_BITS:0]                 t_val;
    logic [2:0][TPROD_BITS-1:0]      tprod_next, tprod_reg;
    vec_t                            pin_m_reg;
    logic                            sel_m_reg, keep_m_reg;

    always_comb
    begin
        t_val = full_reg[T_BITS] ? (T_BITS+1)'(1) << T_BITS : {1'b0, q_reg[T_BITS]};
        for (int k = 0; k < 3; k++)
        begin
            tprod_next[k] = tprod_t'($signed(delta_reg[T_BITS][k]))
                          * tprod_t'($signed({1'b0, t_val}));
        end
    end

    always_ff @(posedge clk)
    begin
        if (go[ST_TMUL])
        begin
            tprod_reg  <= tprod_next;
            pin_m_reg  <= pin_reg[T_BITS];
            sel_m_reg  <= sel_reg[T_BITS];
            keep_m_reg <= keep_reg[T_BITS];
        end
    end

    vec_t      rc;
    clip_out_t out_next, out_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            rc[k] = REL_BITS'(tprod_t'($signed(pin_m_reg[k]))
                            + ($signed(tprod_reg[k]) >>> T_BITS));
        end
        out_next.keep = keep_m_reg;
        out_next.e0   = sel_m_reg ? pin_m_reg : rc;
        out_next.e1   = sel_m_reg ? rc : pin_m_reg;
    end

    always_ff @(posedge clk)
    begin
        if (go[ST_OUT])
        begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;

endmodule

// ----- rtl/snc_project.sv -----
// Back pipeline: screen dot products, visibility, focal scaling, pipelined
// divide by depth and saturating add to the centre. Depends on snc_pkg, snc_dot.
module snc_project (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  snc_pkg::clip_out_t           in_data,
    input  snc_pkg::axes_t               right_axis,
    input  snc_pkg::axes_t               up_axis,
    input  snc_pkg::axes_t               forward_axis,
    input  logic [snc_pkg::FOCAL_BITS-1:0] focal,
    input  logic [2*snc_pkg::CENTRE_BITS-1:0] centre,
    output logic                         out_valid,
    input  logic                         out_ready,
    output snc_pkg::line_t               out_data
);
    import snc_pkg::*;

    localparam int ST_MUL = 0;
    localparam int ST_SUM = 1;
    localparam int ST_CHK = 2;
    localparam int ST_SCL = 3;
    localparam int ST_SAT = 4;
    localparam int ST_OUT = ST_SAT + Q_BITS + 1;
    localparam int NST    = ST_OUT + 1;

    logic [NST-1:0] v_reg;
    logic [NST:0]   go;

    assign go[NST] = out_ready;
    for (genvar s = 0; s < NST; s++)
    begin : g_go
        assign go[s] = !v_reg[s] || go[s+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int s = 0; s < NST; s++)
            begin
                if (go[s])
                begin
                    v_reg[s] <= (s == 0) ? in_valid : v_reg[s-1];
                end
            end
        end
    end

    assign in_ready  = go[0];
    assign out_valid = v_reg[NST-1];

    // axes: 0 right, 1 up, 2 forward
    logic [2:0][AXIS_REG_BITS-1:0] axes;
    dot_t                          dots [2][3];

    assign axes = {forward_axis, up_axis, right_axis};

    for (genvar ge = 0; ge < 2; ge++)
    begin : g_end
        for (genvar ga = 0; ga < 3; ga++)
        begin : g_axis
            snc_dot u_dot (
                .clk    (clk),
                .en_mul (go[ST_MUL]),
                .en_sum (go[ST_SUM]),
                .rel    ((ge == 0) ? in_data.e0 : in_data.e1),
                .axis   (axes[ga]),
                .dot    (dots[ge][ga])
            );
        end
    end

    // live bit: keep before the depth check, draw after it
    logic live_reg [ST_OUT];
    logic vis0, vis1;

    assign vis0 = dots[0][2] > NEAR_DOT;
    assign vis1 = dots[1][2] > NEAR_DOT;

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < ST_OUT; s++)
        begin
            if (go[s])
            begin
                if (s == ST_MUL)
                begin
                    live_reg[s] <= in_data.keep;
                end
                else if (s == ST_CHK)
                begin
                    live_reg[s] <= live_reg[s-1] & vis0 & vis1;
                end
                else
                begin
                    live_reg[s] <= live_reg[s-1];
                end
            end
        end
    end

    // lanes: 0 start x, 1 start y, 2 end x, 3 end y
    logic [MAG_BITS-1:0] mag_reg [4];
    logic                neg_chk [4];
    logic [DEP_BITS-1:0] dep_chk [2];
    logic [NUM_BITS-1:0] n_reg   [4];
    logic                neg_scl [4];
    logic [DEP_BITS-1:0] dep_scl [2];

    always_ff @(posedge clk)
    begin
        if (go[ST_CHK])
        begin
            for (int l = 0; l < 4; l++)
            begin
                neg_chk[l] <= dots[l/2][l%2][DOT_BITS-1];
                mag_reg[l] <= dots[l/2][l%2][DOT_BITS-1]
                            ? MAG_BITS'(~dots[l/2][l%2] + 1'b1)
                            : MAG_BITS'(dots[l/2][l%2]);
            end
            for (int e = 0; e < 2; e++)
            begin
                dep_chk[e] <= dots[e][2][DEP_BITS-1:0];
            end
        end
    end

    logic [MULT_BITS-1:0] mprod [4];

    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            mprod[l] = MULT_BITS'(mag_reg[l]) * MULT_BITS'(focal);
        end
    end

    always_ff @(posedge clk)
    begin
        if (go[ST_SCL])
        begin
            for (int l = 0; l < 4; l++)
            begin
                n_reg[l]   <= mprod[l][MULT_BITS-1:DEN_SHIFT];
                neg_scl[l] <= neg_chk[l];
            end
            dep_scl <= dep_chk;
        end
    end

    // divide by depth; quotient saturates at Q_BITS ones
    logic [DIV_BITS-1:0] rem_reg [Q_BITS+1][4];
    logic [Q_BITS-1:0]   q_reg   [Q_BITS+1][4];
    logic                sat_reg [Q_BITS+1][4];
    logic                neg_reg [Q_BITS+1][4];
    logic [DEP_BITS-1:0] dep_reg [Q_BITS+1][2];

    always_ff @(posedge clk)
    begin
        if (go[ST_SAT])
        begin
            for (int l = 0; l < 4; l++)
            begin
                rem_reg[0][l] <= DIV_BITS'(n_reg[l]);
                q_reg[0][l]   <= '0;
                sat_reg[0][l] <= DIV_BITS'(n_reg[l]) >= (DIV_BITS'(dep_scl[l/2]) << Q_BITS);
                neg_reg[0][l] <= neg_scl[l];
            end
            dep_reg[0] <= dep_scl;
        end
    end

    for (genvar j = 1; j <= Q_BITS; j++)
    begin : g_div
        logic [DIV_BITS-1:0] ds [4];
        logic                ge [4];

        always_comb
        begin
            for (int l = 0; l < 4; l++)
            begin
                ds[l] = DIV_BITS'(dep_reg[j-1][l/2]) << (Q_BITS - j);
                ge[l] = rem_reg[j-1][l] >= ds[l];
            end
        end

        always_ff @(posedge clk)
        begin
            if (go[ST_SAT+j])
            begin
                for (int l = 0; l < 4; l++)
                begin
                    rem_reg[j][l] <= ge[l] ? rem_reg[j-1][l] - ds[l] : rem_reg[j-1][l];
                    q_reg[j][l]   <= {q_reg[j-1][l][Q_BITS-2:0], ge[l]};
                    sat_reg[j][l] <= sat_reg[j-1][l];
                    neg_reg[j][l] <= neg_reg[j-1][l];
                end
                dep_reg[j] <= dep_reg[j-1];
            end
        end
    end

    // signed offset, add to centre x or subtract from centre y, saturate; zero when not live
    logic [Q_BITS-1:0] off_mag [4];
    sx_t               off     [4];
    sx_t               pos     [4];
    screen_t           scr     [4];
    sx_t               cx, cy;
    line_t             out_next, out_reg;

    always_comb
    begin
        cx = sx_t'($signed(centre[CENTRE_BITS-1:0]));
        cy = sx_t'($signed(centre[2*CENTRE_BITS-1:CENTRE_BITS]));
        for (int l = 0; l < 4; l++)
        begin
            off_mag[l] = sat_reg[Q_BITS][l] ? '1 : q_reg[Q_BITS][l];
            off[l]     = neg_reg[Q_BITS][l] ? -sx_t'(off_mag[l]) : sx_t'(off_mag[l]);
            pos[l]     = (l % 2 == 0) ? cx + off[l] : cy - off[l];
            if (!live_reg[ST_OUT-1])
            begin
                scr[l] = '0;
            end
            else if (pos[l] > SCR_MAX)
            begin
                scr[l] = SCREEN_BITS'(SCR_MAX);
            end
            else if (pos[l] < SCR_MIN)
            begin
                scr[l] = SCREEN_BITS'(SCR_MIN);
            end
            else
            begin
                scr[l] = SCREEN_BITS'(pos[l]);
            end
        end
        out_next.draw = live_reg[ST_OUT-1];
        out_next.s0x  = scr[0];
        out_next.s0y  = scr[1];
        out_next.s1x  = scr[2];
        out_next.s1y  = scr[3];
    end

    always_ff @(posedge clk)
    begin
        if (go[ST_OUT])
        begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;

endmodule

// ----- rtl/snc_check.sv -----
// Port-level checks on the result channel, bound to the top level.
// Depends on snc_pkg and segment_near_clip_project.
module snc_check (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic                     draw_line,
    input logic [snc_pkg::SCREEN_BITS-1:0] start_sx,
    input logic [snc_pkg::SCREEN_BITS-1:0] start_sy,
    input logic [snc_pkg::SCREEN_BITS-1:0] end_sx,
    input logic [snc_pkg::SCREEN_BITS-1:0] end_sy
);
    import snc_pkg::*;

    // the cycle after reset is seen, no result is pending
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result valid after reset");

    // a dropped segment carries all-zero coordinates
    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !draw_line |->
            start_sx == '0 && start_sy == '0 && end_sx == '0 && end_sy == '0)
        else $error("dropped line with nonzero coordinates");

    // a blocked beat holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(draw_line)
            && $stable(start_sx) && $stable(start_sy)
            && $stable(end_sx) && $stable(end_sy))
        else $error("result changed while stalled");

endmodule

bind segment_near_clip_project snc_check u_snc_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (screen.valid),
    .out_ready (screen.ready),
    .draw_line (screen.draw_line),
    .start_sx  (screen.start_sx),
    .start_sy  (screen.start_sy),
    .end_sx    (screen.end_sx),
    .end_sy    (screen.end_sy)
);

// ----- tb/snc_line_checker.sv -----
// Checker for the segment near-clip projection block: tracks the register
// writes, predicts one line per accepted segment and compares screen beats.
// Depends on snc_pkg, snc_seg_if and snc_line_if.
module snc_line_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    snc_seg_if                                seg,
    snc_line_if                               scr,
    input  logic                              cfg_we,
    input  logic [snc_pkg::CFG_ADDR_BITS-1:0] cfg_index,
    input  logic [snc_pkg::CFG_DATA_BITS-1:0] cfg_data,
    output int                                fails,
    output int                                pending
);
    import snc_pkg::*;

    // camera copy
    longint           cam_eye [3];
    logic [47:0]      ax_right, ax_up, ax_fwd;
    logic [23:0]      focal;
    logic [39:0]      centre;

    line_t            expected_lines [$];

    function automatic longint axis_comp(logic [47:0] a, int k);
        logic signed [15:0] c;
        c = a[16*k +: 16];
        return longint'(c);
    endfunction

    // Q.16 vector dot Q2.14 axis, floored to Q.16
    function automatic longint axis_dot(longint v [3], logic [47:0] a);
        longint hi, lo, rh, rl, b;
        hi = 0;
        lo = 0;
        for (int k = 0; k < 3; k++)
        begin
            b  = axis_comp(a, k);
            rh = v[k] >>> 14;
            rl = v[k] - rh * 16384;
            hi += rh * b;
            lo += rl * b;
        end
        return hi + (lo >>> 14);
    endfunction

    function automatic longint sat_screen(longint v);
        if (v > 524287)
            return 524287;
        if (v < -524288)
            return -524288;
        return v;
    endfunction

    // |a| * focal / den, truncated, capped at 2^40
    function automatic longint scaled_offset(longint a, longint unsigned den);
        longint unsigned mag, q, r, acc, rem, res, cap, f;
        cap = 64'd1 << 40;
        f   = 64'(focal);
        mag = a < 0 ? longint'(-a) : a;
        q   = mag / den;
        r   = mag % den;
        acc = 0;
        rem = 0;
        if (q >= cap)
            res = cap;
        else
        begin
            for (int i = FOCAL_BITS - 1; i >= 0; i--)
            begin
                acc = acc << 1;
                rem = rem << 1;
                if (f[i])
                    rem += r;
                while (rem >= den)
                begin
                    rem -= den;
                    acc++;
                end
            end
            res = q * f + acc;
            if (res > cap)
                res = cap;
        end
        return a < 0 ? -longint'(res) : longint'(res);
    endfunction

    function automatic bit screen_point(longint v [3], output longint sx, output longint sy,
                                        output longint depth);
        logic signed [19:0] cx, cy;
        longint unsigned den;
        cx    = centre[19:0];
        cy    = centre[39:20];
        sx    = 0;
        sy    = 0;
        depth = axis_dot(v, ax_fwd);
        if (depth <= HIDE_DEPTH)
            return 0;
        den = longint'(depth) * 16;
        sx  = sat_screen(longint'(cx) + scaled_offset(axis_dot(v, ax_right), den));
        sy  = sat_screen(longint'(cy) - scaled_offset(axis_dot(v, ax_up), den));
        return 1;
    endfunction

    function automatic line_t project_segment(world_t w [6]);
        longint ra [3], rb [3], rc [3], pin [3], pout [3];
        longint ax, ay, bx, by, cx, cy, da, db, dc, din, dout, span, num;
        longint delta, dh, dl;
        longint unsigned t, r, d;
        bit     va, vb;
        line_t  ln;
        ln = '0;
        for (int k = 0; k < 3; k++)
        begin
            ra[k] = longint'(w[k]) - cam_eye[k];
            rb[k] = longint'(w[3+k]) - cam_eye[k];
        end
        va = screen_point(ra, ax, ay, da);
        vb = screen_point(rb, bx, by, db);
        if (va && vb)
        begin
            ln = '{1'b1, screen_t'(ax), screen_t'(ay), screen_t'(bx), screen_t'(by)};
        end
        else if (va || vb)
        begin
            for (int k = 0; k < 3; k++)
            begin
                pin[k]  = va ? ra[k] : rb[k];
                pout[k] = va ? rb[k] : ra[k];
            end
            din  = va ? da : db;
            dout = va ? db : da;
            span = din - dout;
            if (span > 0)
            begin
                num = din - CLIP_DEPTH;
                if (num <= 0)
                    t = 0;
                else if (num >= span)
                    t = 64'd1 << T_BITS;
                else
                begin
                    r = num;
                    d = span;
                    t = 0;
                    for (int k = 0; k < T_BITS; k++)
                    begin
                        r = r << 1;
                        t = t << 1;
                        if (r >= d)
                        begin
                            r -= d;
                            t |= 1;
                        end
                    end
                end
                for (int k = 0; k < 3; k++)
                begin
                    delta = pout[k] - pin[k];
                    dh    = delta >>> T_BITS;
                    dl    = delta - dh * 65536;
                    rc[k] = pin[k] + dh * longint'(t) + ((dl * longint'(t)) >>> T_BITS);
                end
                if (screen_point(rc, cx, cy, dc))
                begin
                    if (va)
                        ln = '{1'b1, screen_t'(ax), screen_t'(ay), screen_t'(cx),
                               screen_t'(cy)};
                    else
                        ln = '{1'b1, screen_t'(cx), screen_t'(cy), screen_t'(bx),
                               screen_t'(by)};
                end
            end
        end
        return ln;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_eye  = '{0, 0, 0};
            ax_right = '0;
            ax_up    = '0;
            ax_fwd   = '0;
            focal    = 24'(FOCAL_RESET);
            centre   = '0;
            expected_lines.delete();
            fails    = 0;
            pending  = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_EYE_X:         cam_eye[0] = longint'(world_t'(cfg_data[31:0]));
                    REG_EYE_Y:         cam_eye[1] = longint'(world_t'(cfg_data[31:0]));
                    REG_EYE_Z:         cam_eye[2] = longint'(world_t'(cfg_data[31:0]));
                    REG_RIGHT_AXIS:    ax_right   = cfg_data;
                    REG_UP_AXIS:       ax_up      = cfg_data;
                    REG_FORWARD_AXIS:  ax_fwd     = cfg_data;
                    REG_FOCAL_PIXELS:  focal      = cfg_data[23:0];
                    REG_SCREEN_CENTRE: centre     = cfg_data[39:0];
                    default: ;
                endcase
            end
            if (scr.valid && scr.ready)
            begin
                line_t got, exp_ln;
                got = '{scr.draw_line, scr.start_sx, scr.start_sy, scr.end_sx, scr.end_sy};
                if (expected_lines.size() == 0)
                begin
                    $error("unexpected screen beat draw=%0b", got.draw);
                    fails++;
                end
                else
                begin
                    exp_ln = expected_lines.pop_front();
                    if (got.draw !== exp_ln.draw)
                    begin
                        $error("draw_line exp %0b got %0b", exp_ln.draw, got.draw);
                        fails++;
                    end
                    if (got.s0x !== exp_ln.s0x)
                    begin
                        $error("start_sx exp %0d got %0d", exp_ln.s0x, got.s0x);
                        fails++;
                    end
                    if (got.s0y !== exp_ln.s0y)
                    begin
                        $error("start_sy exp %0d got %0d", exp_ln.s0y, got.s0y);
                        fails++;
                    end
                    if (got.s1x !== exp_ln.s1x)
                    begin
                        $error("end_sx exp %0d got %0d", exp_ln.s1x, got.s1x);
                        fails++;
                    end
                    if (got.s1y !== exp_ln.s1y)
                    begin
                        $error("end_sy exp %0d got %0d", exp_ln.s1y, got.s1y);
                        fails++;
                    end
                end
            end
            if (seg.valid && seg.ready)
            begin
                world_t w [6];
                w = '{seg.start_wx, seg.start_wy, seg.start_wz,
                      seg.end_wx, seg.end_wy, seg.end_wz};
                expected_lines = {expected_lines, project_segment(w)};
            end
            pending = expected_lines.size();
        end
    end

endmodule

// ----- tb/tb.sv -----
// Testbench top for segment_near_clip_project: clock, reset, register phases,
// segment stimulus and the verdict. Depends on snc_pkg, both channel
// interfaces, the block and snc_line_checker.
module tb;
    import snc_pkg::*;

    logic clk;
    logic rst_n;
    logic                     cfg_we;
    logic [CFG_ADDR_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    int   fails;
    int   pending;

    // current eye, used to aim segments near the camera
    world_t eye_now [3];
    // set by the sender, served by the ready process
    bit     long_hold;
    // 0: random stalls, 1: ready always high
    bit     ready_free;
    int     sent;

    snc_seg_if  seg ();
    snc_line_if scr ();

    segment_near_clip_project u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .segment   (seg),
        .screen    (scr),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    snc_line_checker u_chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .seg       (seg),
        .scr       (scr),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fails     (fails),
        .pending   (pending)
    );

    initial clk = 0;
    always #10 clk = ~clk;

    // Hard stop, far above the slowest legal run.
    initial
    begin
        #40000000;
        $display("CHECK FAILED");
        $finish;
    end

    // Mostly short gaps, a few long ones.
    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 65)
            return 0;
        if (p < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Output side back-pressure. A long hold lets the 49-stage pipe fill up
    // so segment.ready has to drop.
    initial
    begin
        int g;
        scr.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                scr.ready <= 1'b0;
                repeat (300) @(posedge clk);
                long_hold = 0;
                scr.ready <= 1'b1;
            end
            else
            begin
                g = ready_free ? 0 : gap_len();
                if (g == 0)
                    scr.ready <= 1'b1;
                else
                begin
                    scr.ready <= 1'b0;
                    repeat (g) @(posedge clk);
                    scr.ready <= 1'b1;
                end
            end
        end
    end

    // One beat on the segment channel. Called at a rising edge; returns at
    // the edge that accepted the beat, with valid still high.
    task automatic send_seg(wvec_t a, wvec_t b);
        int  g;
        bit  rdy;
        g = ready_free ? 0 : gap_len();
        if (g > 0)
        begin
            seg.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        seg.valid    <= 1'b1;
        seg.start_wx <= a[0];
        seg.start_wy <= a[1];
        seg.start_wz <= a[2];
        seg.end_wx   <= b[0];
        seg.end_wy   <= b[1];
        seg.end_wz   <= b[2];
        do
        begin
            @(negedge clk);
            rdy = seg.ready;
            @(posedge clk);
        end
        while (!rdy);
        sent++;
    endtask

    // Drop valid and wait for every line in flight, then pause before returning.
    task automatic drain();
        seg.valid <= 1'b0;
        @(negedge clk);
        wait (pending == 0);
        repeat (60) @(posedge clk);
    endtask

    task automatic cfg_write(cfg_reg_t r, logic [CFG_DATA_BITS-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_data  <= d;
        @(posedge clk);
    endtask

    function automatic logic [47:0] pack_axis(int x, int y, int z);
        return {16'(z), 16'(y), 16'(x)};
    endfunction

    // Point given as x, y, z.
    function automatic wvec_t xyz(world_t x, world_t y, world_t z);
        return {z, y, x};
    endfunction

    // Point near the eye at a random scale; sometimes anything at all.
    function automatic wvec_t near_point();
        wvec_t p;
        int    s;
        for (int k = 0; k < 3; k++)
        begin
            s = $urandom_range(4, 30);
            p[k] = eye_now[k] + world_t'($signed($urandom) >>> (31 - s));
        end
        if ($urandom_range(9) == 0)
            p = {$urandom, $urandom, $urandom};
        return p;
    endfunction

    // Axis with a strong unit component and a small random tilt, or raw bits.
    function automatic logic [47:0] rand_axis(int main, bit neg);
        int c [3];
        if ($urandom_range(7) == 0)
            return 48'({$urandom, $urandom});
        for (int k = 0; k < 3; k++)
            c[k] = $urandom_range(0, 4000) - 2000;
        c[main] = neg ? -16384 + c[main] / 4 : 16384 + c[main] / 4;
        if (c[main] > 32767)
            c[main] = 32767;
        return pack_axis(c[0], c[1], c[2]);
    endfunction

    task automatic set_eye(world_t x, world_t y, world_t z);
        eye_now = '{x, y, z};
        cfg_write(REG_EYE_X, 48'(x));
        cfg_write(REG_EYE_Y, 48'(y));
        cfg_write(REG_EYE_Z, 48'(z));
    endtask

    task automatic random_camera(int phase);
        logic [23:0] f;
        logic [39:0] cen;
        int          m;
        m = phase % 4;
        if (m == 0)
            set_eye(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
        else if (m == 1)
            set_eye(32'sh80000000, 32'sh7fffffff, 32'sh80000000);
        else
            set_eye($urandom >> 10, $urandom >> 10, $urandom >> 10);
        cfg_write(REG_RIGHT_AXIS, rand_axis(0, phase % 5 == 3));
        cfg_write(REG_UP_AXIS, rand_axis(1, phase % 3 == 2));
        cfg_write(REG_FORWARD_AXIS, rand_axis(2, phase % 7 == 6));
        case (phase % 5)
            0:       f = 24'hffffff;
            1:       f = 24'd0;
            2:       f = 24'd256;
            default: f = 24'($urandom);
        endcase
        cfg_write(REG_FOCAL_PIXELS, 48'(f));
        case (phase % 3)
            0:       cen = {20'h7ffff, 20'h80000};
            1:       cen = {20'h80000, 20'h7ffff};
            default: cen = 40'({$urandom, $urandom});
        endcase
        cfg_write(REG_SCREEN_CENTRE, 48'(cen));
        cfg_we <= 1'b0;
    endtask

    localparam world_t W_MAX = 32'sh7fffffff;
    localparam world_t W_MIN = 32'sh80000000;

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        seg.valid    = 1'b0;
        seg.start_wx = '0;
        seg.start_wy = '0;
        seg.start_wz = '0;
        seg.end_wx   = '0;
        seg.end_wy   = '0;
        seg.end_wz   = '0;
        eye_now      = '{0, 0, 0};
        long_hold    = 0;
        ready_free   = 0;
        sent         = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset camera: zero basis, everything dropped.
        send_seg(xyz(W_MAX, W_MAX, W_MAX), xyz(W_MIN, W_MIN, W_MIN));
        send_seg(xyz(W_MIN, 32'sd0, W_MAX), xyz(32'sd65536, 32'sd0, 32'sd0));
        drain();

        // Plain camera: right x, up y, forward z, focal 1.0, centre 0.
        set_eye(0, 0, 0);
        cfg_write(REG_RIGHT_AXIS, pack_axis(16384, 0, 0));
        cfg_write(REG_UP_AXIS, pack_axis(0, 16384, 0));
        cfg_write(REG_FORWARD_AXIS, pack_axis(0, 0, 16384));
        cfg_write(REG_FOCAL_PIXELS, 48'd256);
        cfg_write(REG_SCREEN_CENTRE, 48'd0);
        cfg_we <= 1'b0;
        @(posedge clk);
        // both ends visible
        send_seg(xyz(32'sd65536, 32'sd131072, 32'sd655360),
                 xyz(-32'sd65536, 32'sd0, 32'sd327680));
        // end behind: clipped end
        send_seg(xyz(32'sd65536, 32'sd65536, 32'sd655360), xyz(32'sd0, 32'sd0, -32'sd655360));
        // start behind: clipped start
        send_seg(xyz(32'sd0, 32'sd0, -32'sd65536), xyz(32'sd65536, -32'sd65536, 32'sd65536));
        // both hidden
        send_seg(xyz(32'sd0, 32'sd0, -32'sd5), xyz(32'sd100, 32'sd0, 32'sd7));
        // just past the near plane on one end, so the clip lands at t = 0
        send_seg(xyz(32'sd65536, 32'sd0, 32'sd8), xyz(32'sd0, 32'sd0, -32'sd1));
        // hidden end right at the plane, clip half way
        send_seg(xyz(32'sd0, 32'sd0, 32'sd9), xyz(32'sd65536, 32'sd0, 32'sd7));
        // huge lateral offset at tiny depth: saturation and the offset cap
        send_seg(xyz(W_MAX, W_MIN, 32'sd8), xyz(W_MIN, W_MAX, 32'sd9));
        send_seg(xyz(W_MAX, W_MAX, W_MAX), xyz(W_MIN, W_MIN, W_MAX));
        send_seg(xyz(W_MIN, W_MIN, W_MIN), xyz(W_MAX, W_MAX, W_MAX));
        send_seg(xyz(32'sd0, 32'sd0, 32'sd0), xyz(32'sd0, 32'sd0, 32'sd0));
        drain();

        // Random phases; each ends with a full drain, which is also the
        // sender pause that waits for every line in flight.
        for (int phase = 0; phase < 13; phase++)
        begin
            random_camera(phase);
            @(posedge clk);
            ready_free = (phase % 4 == 2);
            for (int i = 0; i < 110; i++)
            begin
                if (phase == 5 && i == 20)
                    long_hold = 1;
                send_seg(near_point(), near_point());
            end
            drain();
        end

        if (fails == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
